// ===== src/assert_macros.svh =====
// assertion helpers shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while in reset
`define PCMN_ASSERT_NOW(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("pcmn assertion failed");

// next-cycle implication, disabled while in reset
`define PCMN_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("pcmn assertion failed");

`endif

// ===== src/pcmn_pkg.sv =====
`default_nettype none

package pcmn_pkg;

  localparam int unsigned WORD_W = 16;
  localparam int unsigned BYTE_W = 8;
  localparam int unsigned REG_IDX_W = 3;

  localparam logic [WORD_W-1:0] SIGN_WIDE = 16'h8000;
  localparam logic [WORD_W-1:0] SIGN_NARROW = 16'h0080;

  typedef enum logic [REG_IDX_W-1:0] {
    REG_WIDE_SAMPLES       = 3'd0,
    REG_INTERLEAVED_STEREO = 3'd1,
    REG_BIG_ENDIAN_WORDS   = 3'd2,
    REG_DELTA_CODED        = 3'd3,
    REG_UNSIGNED_CODED     = 3'd4
  } reg_idx_t;

  typedef struct packed {
    logic wide_samples;
    logic interleaved_stereo;
    logic big_endian_words;
    logic delta_coded;
    logic unsigned_coded;
  } cfg_t;

  typedef struct packed {
    logic [WORD_W-1:0] left_running;
    logic [WORD_W-1:0] right_running;
    logic              channel_phase;
  } chan_state_t;

endpackage

`default_nettype wire

// ===== src/pcmn_if.sv =====
`default_nettype none

interface pcmn_cfg_if;
  logic       valid;
  logic       ready;
  logic [2:0] reg_index;
  logic       write_data;
  modport source (output valid, reg_index, write_data, input ready);
  modport sink (input valid, reg_index, write_data, output ready);
endinterface

interface pcmn_in_if;
  logic        valid;
  logic        ready;
  logic [15:0] raw_word;
  logic        last_in_sample;
  modport source (output valid, raw_word, last_in_sample, input ready);
  modport sink (input valid, raw_word, last_in_sample, output ready);
endinterface

interface pcmn_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] converted_word;
  logic        right_channel;
  modport source (output valid, converted_word, right_channel, input ready);
  modport sink (input valid, converted_word, right_channel, output ready);
endinterface

`default_nettype wire

// ===== src/pcmn_convert.sv =====
`default_nettype none

module pcmn_convert (
  input  pcmn_pkg::cfg_t        cfg,
  input  pcmn_pkg::chan_state_t state,
  input  logic [15:0]           raw_word,
  input  logic                  last_in_sample,
  output logic [15:0]           converted_word,
  output logic                  right_channel,
  output pcmn_pkg::chan_state_t state_next
);
  import pcmn_pkg::*;

  logic [WORD_W-1:0] word;
  logic [WORD_W-1:0] prev;
  logic [WORD_W-1:0] sum;
  logic [WORD_W-1:0] result;
  logic              ch;

  always_comb begin
    if (cfg.wide_samples) begin
      word = cfg.big_endian_words ? {raw_word[BYTE_W-1:0], raw_word[WORD_W-1:BYTE_W]}
                                  : raw_word;
    end else begin
      word = {{(WORD_W-BYTE_W){1'b0}}, raw_word[BYTE_W-1:0]};
    end

    ch = cfg.interleaved_stereo & state.channel_phase;
    prev = ch ? state.right_running : state.left_running;
    sum = prev + word;

    if (cfg.delta_coded) begin
      result = cfg.wide_samples ? sum : {{(WORD_W-BYTE_W){1'b0}}, sum[BYTE_W-1:0]};
    end else if (cfg.unsigned_coded) begin
      result = word ^ (cfg.wide_samples ? SIGN_WIDE : SIGN_NARROW);
    end else begin
      result = word;
    end

    state_next = state;
    if (cfg.delta_coded) begin
      if (ch) begin
        state_next.right_running = result;
      end else begin
        state_next.left_running = result;
      end
    end
    if (cfg.interleaved_stereo) begin
      state_next.channel_phase = ~state.channel_phase;
    end
    if (last_in_sample) begin
      state_next = '0;
    end

    converted_word = result;
    right_channel = ch;
  end

endmodule

`default_nettype wire

// ===== src/pcm_sample_format_normalizer_core.sv =====
// channel  role    payload
// cfg      sink    reg_index, write_data
// sample   sink    raw_word, last_in_sample
// result   source  converted_word, right_channel
//
// an accepted sample is held in the input register, then converted into the output register
// one sample per cycle unless the result stalls; the channel accumulators update in one add-and-store step
// rst clears the configuration, accumulators, channel phase and both valid flags
// a stalled result holds the output; the input register takes one more sample only if it is empty
`default_nettype none

`include "assert_macros.svh"

module pcm_sample_format_normalizer_core (
  input logic       clk,
  input logic       rst,
  pcmn_cfg_if.sink  cfg,
  pcmn_in_if.sink   sample,
  pcmn_out_if.source result
);
  import pcmn_pkg::*;

  cfg_t              cfg_q;
  chan_state_t       state;
  chan_state_t       state_next;

  logic              in_valid;
  logic [WORD_W-1:0] in_word;
  logic              in_last;

  logic              out_valid;
  logic [WORD_W-1:0] out_word;
  logic              out_right;

  logic [WORD_W-1:0] conv_word;
  logic              conv_right;
  logic              advance;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_q <= '0;
    end else if (cfg.valid) begin
      case (cfg.reg_index)
        REG_WIDE_SAMPLES:       cfg_q.wide_samples <= cfg.write_data;
        REG_INTERLEAVED_STEREO: cfg_q.interleaved_stereo <= cfg.write_data;
        REG_BIG_ENDIAN_WORDS:   cfg_q.big_endian_words <= cfg.write_data;
        REG_DELTA_CODED:        cfg_q.delta_coded <= cfg.write_data;
        REG_UNSIGNED_CODED:     cfg_q.unsigned_coded <= cfg.write_data;
        default: ;
      endcase
    end
  end

  assign advance = in_valid && (!out_valid || result.ready);
  assign sample.ready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (sample.ready) begin
      in_valid <= sample.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (sample.valid && sample.ready) begin
      in_word <= sample.raw_word;
      in_last <= sample.last_in_sample;
    end
  end

  pcmn_convert u_convert (
    .cfg            (cfg_q),
    .state          (state),
    .raw_word       (in_word),
    .last_in_sample (in_last),
    .converted_word (conv_word),
    .right_channel  (conv_right),
    .state_next     (state_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= '0;
    end else if (advance) begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_word <= conv_word;
      out_right <= conv_right;
    end
  end

  assign result.valid = out_valid;
  assign result.converted_word = out_word;
  assign result.right_channel = out_right;

  `PCMN_ASSERT_NOW(a_narrow_upper_zero, clk, rst,
    advance && !cfg_q.wide_samples, conv_word[WORD_W-1:BYTE_W] == '0)
  `PCMN_ASSERT_NOW(a_right_only_stereo, clk, rst,
    advance && conv_right, cfg_q.interleaved_stereo && state.channel_phase)
  `PCMN_ASSERT_NEXT(a_last_clears_state, clk, rst,
    advance && in_last, state == '0)
  `PCMN_ASSERT_NEXT(a_mono_keeps_phase, clk, rst,
    advance && !in_last && !cfg_q.interleaved_stereo, $stable(state.channel_phase))

endmodule

`default_nettype wire
